>>> hw/rtl/era_pkg.sv
// ----------------------------------------------------------------------------
// era_pkg
// Types and constants shared by the emission rate accumulator modules.
// ----------------------------------------------------------------------------
package era_pkg;

   localparam logic [11:0] STEP_MAX          = 12'd2185;
   localparam logic [47:0] ELAPSED_MAX       = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] RATE_RESET        = 32'd655360;
   localparam logic [31:0] BURST_START_RESET = 32'hFFFF_0000;
   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
   localparam logic [4:0]  ROOT_LAST         = 5'd31;

   localparam logic [2:0] REG_RATE         = 3'd0;
   localparam logic [2:0] REG_DENSITY      = 3'd1;
   localparam logic [2:0] REG_BURST_START  = 3'd2;
   localparam logic [2:0] REG_BURST_SIZE   = 3'd3;
   localparam logic [2:0] REG_BURST_PERIOD = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3,
      ST_R0, ST_R1, ST_R2, ST_R3, ST_ROOT,
      ST_D0, ST_D1, ST_D2, ST_D3, ST_D4,
      ST_FIN, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_SQX, MUL_SQY, MUL_SQZ, MUL_RATE, MUL_DENS, MUL_LO, MUL_HI
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_SUM, ACC_PROD, ACC_TOT_LO, ACC_TOT_HI
   } acc_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        root_init;
      logic        root_step;
      logic        finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scale_pos;
   } dp_status_type;

   typedef struct packed {
      logic [31:0] rate;
      logic [31:0] density;
      logic [31:0] burst_start;
      logic [15:0] burst_size;
      logic [30:0] burst_period;
   } cfg_type;

endpackage

>>> hw/rtl/era_if.sv
// ----------------------------------------------------------------------------
// era_if
// Valid/ready channels for frame items and spawn results.
// ----------------------------------------------------------------------------
interface era_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] delta_time;
   logic signed [31:0] move_x;
   logic signed [31:0] move_y;
   logic signed [31:0] move_z;
   logic signed [17:0] rate_scale;

   modport source  (output valid, delta_time, move_x, move_y, move_z, rate_scale, input ready);
   modport sink    (input valid, delta_time, move_x, move_y, move_z, rate_scale, output ready);
   modport monitor (input valid, ready, delta_time, move_x, move_y, move_z, rate_scale);
endinterface

interface era_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] spawn_count;
   logic        burst_fired;
   logic        count_saturated;

   modport source  (output valid, spawn_count, burst_fired, count_saturated, input ready);
   modport sink    (input valid, spawn_count, burst_fired, count_saturated, output ready);
   modport monitor (input valid, ready, spawn_count, burst_fired, count_saturated);
endinterface

>>> hw/rtl/era_csr.sv
// ----------------------------------------------------------------------------
// era_csr
// APB register file for rate, density and burst settings.
// ----------------------------------------------------------------------------
module era_csr
   import era_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg,
   output logic        start_wr
);

   cfg_type    cfg_ff;
   logic       wr;
   logic [2:0] idx;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
   assign start_wr   = wr && (idx == REG_BURST_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate         <= RATE_RESET;
         cfg_ff.density      <= '0;
         cfg_ff.burst_start  <= BURST_START_RESET;
         cfg_ff.burst_size   <= '0;
         cfg_ff.burst_period <= '0;
      end else if (wr) begin
         case (idx)
            REG_RATE:         cfg_ff.rate         <= csr_pwdata;
            REG_DENSITY:      cfg_ff.density      <= csr_pwdata;
            REG_BURST_START:  cfg_ff.burst_start  <= csr_pwdata;
            REG_BURST_SIZE:   cfg_ff.burst_size   <= csr_pwdata[15:0];
            REG_BURST_PERIOD: cfg_ff.burst_period <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RATE:         csr_prdata = cfg_ff.rate;
         REG_DENSITY:      csr_prdata = cfg_ff.density;
         REG_BURST_START:  csr_prdata = cfg_ff.burst_start;
         REG_BURST_SIZE:   csr_prdata = {16'd0, cfg_ff.burst_size};
         REG_BURST_PERIOD: csr_prdata = {1'b0, cfg_ff.burst_period};
         default:          csr_prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/era_datapath.sv
// ----------------------------------------------------------------------------
// era_datapath
// Shared 32x32 multiplier, accumulators, bitwise square root and burst logic.
// ----------------------------------------------------------------------------
module era_datapath
   import era_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  cfg_type       cfg,
   input  logic          start_wr,
   input  logic [31:0]   start_value,
   input  logic [31:0]   delta_time,
   input  logic [31:0]   move_x,
   input  logic [31:0]   move_y,
   input  logic [31:0]   move_z,
   input  logic [17:0]   rate_scale,
   output logic [15:0]   spawn_count,
   output logic          burst_fired,
   output logic          count_saturated
);

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   logic [31:0] dt_ff, magx_ff, magy_ff, magz_ff;
   logic [11:0] step_ff;
   logic [16:0] sc_ff;
   logic        scale_pos_ff;
   logic [63:0] sum_ff, p_ff, m_ff;
   logic [49:0] total_ff;
   logic [32:0] rem_ff;
   logic [31:0] root_ff;
   logic [15:0] frac_ff;
   logic [33:0] deadline_ff;
   logic [47:0] elapsed_ff;
   logic [15:0] count_ff;
   logic        fired_ff, sat_ff;

   logic [31:0] op_a, op_b;
   logic [34:0] rem_sh, trial, rem_diff;
   logic        ge;

   logic [33:0] cnt34;
   logic [34:0] cnt_sum;
   logic        dl_pos, fire, restart;
   logic [48:0] el_plus, dlx, el_new;
   logic [47:0] el_base;

   assign status.scale_pos = scale_pos_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_SQX:  begin op_a = magx_ff;         op_b = magx_ff;         end
         MUL_SQY:  begin op_a = magy_ff;         op_b = magy_ff;         end
         MUL_SQZ:  begin op_a = magz_ff;         op_b = magz_ff;         end
         MUL_RATE: begin op_a = {20'd0, step_ff}; op_b = cfg.rate;       end
         MUL_DENS: begin op_a = root_ff;         op_b = cfg.density;     end
         MUL_LO:   begin op_a = m_ff[31:0];      op_b = {15'd0, sc_ff};  end
         MUL_HI:   begin op_a = m_ff[63:32];     op_b = {15'd0, sc_ff};  end
         default:  begin op_a = '0;              op_b = '0;              end
      endcase
   end

   // one root bit per step, two radicand bits shifted in
   assign rem_sh   = {rem_ff, sum_ff[63:62]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign ge       = rem_sh >= trial;
   assign rem_diff = ge ? (rem_sh - trial) : rem_sh;

   // burst timing uses the raw step
   assign cnt34   = total_ff[49:16];
   assign dl_pos  = !deadline_ff[33] && (deadline_ff != '0);
   assign el_plus = {1'b0, elapsed_ff} + {17'd0, dt_ff};
   assign dlx     = {15'd0, deadline_ff};
   assign fire    = dl_pos && (el_plus > dlx) && ({1'b0, elapsed_ff} <= dlx);
   assign restart = fire && (cfg.burst_period != '0);
   assign el_base = restart ? '0 : elapsed_ff;
   assign el_new  = {1'b0, el_base} + {17'd0, dt_ff};
   assign cnt_sum = {1'b0, cnt34} + (fire ? {19'd0, cfg.burst_size} : 35'd0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dt_ff        <= delta_time;
         step_ff      <= (delta_time < {20'd0, STEP_MAX}) ? delta_time[11:0] : STEP_MAX;
         sc_ff        <= rate_scale[16:0];
         scale_pos_ff <= (rate_scale != '0) && !rate_scale[17];
         magx_ff      <= mag32(move_x);
         magy_ff      <= mag32(move_y);
         magz_ff      <= mag32(move_z);
         sum_ff       <= '0;
         total_ff     <= {34'd0, frac_ff};
      end else begin
         if (cmd.mul_en) begin
            p_ff <= op_a * op_b;
         end
         case (cmd.acc_sel)
            ACC_SUM:    sum_ff   <= sum_ff + p_ff;
            ACC_PROD:   m_ff     <= p_ff;
            ACC_TOT_LO: total_ff <= total_ff + {18'd0, p_ff[63:32]};
            ACC_TOT_HI: total_ff <= total_ff + p_ff[49:0];
            default: ;
         endcase
         if (cmd.root_init) begin
            rem_ff  <= '0;
            root_ff <= '0;
         end
         if (cmd.root_step) begin
            rem_ff  <= rem_diff[32:0];
            root_ff <= {root_ff[30:0], ge};
            sum_ff  <= {sum_ff[61:0], 2'b00};
         end
      end
      if (cmd.finish) begin
         fired_ff <= fire;
         if (cnt_sum > {19'd0, COUNT_MAX}) begin
            count_ff <= COUNT_MAX;
            sat_ff   <= 1'b1;
         end else begin
            count_ff <= cnt_sum[15:0];
            sat_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff     <= '0;
         deadline_ff <= {{2{BURST_START_RESET[31]}}, BURST_START_RESET};
         elapsed_ff  <= '0;
      end else begin
         if (cmd.finish) begin
            frac_ff <= total_ff[15:0];
            if (dl_pos) begin
               elapsed_ff <= el_new[48] ? ELAPSED_MAX : el_new[47:0];
               if (restart) begin
                  deadline_ff <= {3'd0, cfg.burst_period} + {2'd0, dt_ff};
               end
            end
         end
         if (start_wr) begin
            deadline_ff <= {{2{start_value[31]}}, start_value};
         end
      end
   end

   assign spawn_count     = count_ff;
   assign burst_fired     = fired_ff;
   assign count_saturated = sat_ff;

endmodule

>>> hw/rtl/era_ctrl.sv
// ----------------------------------------------------------------------------
// era_ctrl
// Sequencer for the multiply, square root and finish steps of one item.
// ----------------------------------------------------------------------------
module era_ctrl
   import era_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type  state_ff, state_in;
   logic [4:0] ctr_ff, ctr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctr_in   = ctr_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SQ0;
         ST_SQ0:  state_in = status.scale_pos ? ST_SQ1 : ST_FIN;
         ST_SQ1:  state_in = ST_SQ2;
         ST_SQ2:  state_in = ST_SQ3;
         ST_SQ3:  state_in = ST_R0;
         ST_R0:   state_in = ST_R1;
         ST_R1:   state_in = ST_R2;
         ST_R2:   state_in = ST_R3;
         ST_R3:   state_in = ST_ROOT;
         ST_ROOT: begin
            ctr_in = ctr_ff + 5'd1;
            if (ctr_ff == ROOT_LAST) state_in = ST_D0;
         end
         ST_D0:   state_in = ST_D1;
         ST_D1:   state_in = ST_D2;
         ST_D2:   state_in = ST_D3;
         ST_D3:   state_in = ST_D4;
         ST_D4:   state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = MUL_SQX;
      cmd.acc_sel   = ACC_NONE;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQ0: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQX; end
         ST_SQ1: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQY; cmd.acc_sel = ACC_SUM; end
         ST_SQ2: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQZ; cmd.acc_sel = ACC_SUM; end
         ST_SQ3: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RATE; cmd.acc_sel = ACC_SUM; end
         ST_R0:  cmd.acc_sel = ACC_PROD;
         ST_R1:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_LO; end
         ST_R2:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_HI; cmd.acc_sel = ACC_TOT_LO; end
         ST_R3:  begin cmd.acc_sel = ACC_TOT_HI; cmd.root_init = 1'b1; end
         ST_ROOT: cmd.root_step = 1'b1;
         ST_D0:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DENS; end
         ST_D1:  cmd.acc_sel = ACC_PROD;
         ST_D2:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_LO; end
         ST_D3:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_HI; cmd.acc_sel = ACC_TOT_LO; end
         ST_D4:  cmd.acc_sel = ACC_TOT_HI;
         ST_FIN: cmd.finish = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/emission_rate_accumulator.sv
// ----------------------------------------------------------------------------
// emission_rate_accumulator
// Per-frame particle spawn count from rate, distance moved and bursts.
//
//   channel   direction  carries
//   req_bus   in         delta_time, move_x/y/z, rate_scale
//   rsp_bus   out        spawn_count, burst_fired, count_saturated
//   csr_*     in/out     APB writes/reads of the five settings
//
// From acceptance to a valid result an item runs through the shared 32x32
// multiplier sequence, the bitwise square root, a second multiplier pass and
// the finish step; a non-positive rate_scale skips straight to the finish.
// One item at a time: req ready is high only while idle, and drops until the
// result has been taken. Synchronous reset clears fraction, elapsed time and
// the burst deadline, which reloads from the burst_start reset value.
// ----------------------------------------------------------------------------
module emission_rate_accumulator
   import era_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   era_req_if.sink     req_bus,
   era_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg;
   logic          start_wr;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   era_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .start_wr    (start_wr)
   );

   era_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   era_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .start_wr        (start_wr),
      .start_value     (csr_pwdata),
      .delta_time      (req_bus.delta_time),
      .move_x          (req_bus.move_x),
      .move_y          (req_bus.move_y),
      .move_z          (req_bus.move_z),
      .rate_scale      (req_bus.rate_scale),
      .spawn_count     (rsp_bus.spawn_count),
      .burst_fired     (rsp_bus.burst_fired),
      .count_saturated (rsp_bus.count_saturated)
   );

endmodule

>>> hw/rtl/era_checker.sv
// ----------------------------------------------------------------------------
// era_checker
// Port-level checks on the accumulator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module era_checker (
   input logic       clock,
   input logic       reset,
   era_req_if.sink   req_bus,
   era_rsp_if.source rsp_bus
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.spawn_count))
      else $error("stalled result changed");

   // one item in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("input taken while result pending");

   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready && !rsp_bus.valid)
      else $error("block not busy after accepting item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.count_saturated |-> rsp_bus.spawn_count == 16'hFFFF)
      else $error("saturated count not at maximum");

   assert property (@(posedge clock)
      reset |=> req_bus.ready && !rsp_bus.valid)
      else $error("not idle after reset");

endmodule

bind emission_rate_accumulator era_checker u_era_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
